@@ rtl/wildcard_glob_matcher_defines.svh @@
// Assertion macros used by the glob matcher checker.
// Each macro expects signals clk and arst_n in the scope where it is used.
`ifndef WILDCARD_GLOB_MATCHER_DEFINES_SVH
`define WILDCARD_GLOB_MATCHER_DEFINES_SVH

// Same-cycle implication, skipped while reset is asserted.
`define WGM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, skipped while reset is asserted.
`define WGM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/wgm_pkg.sv @@
// Shared types and constants of the glob matcher.
// No dependencies; used by the cell, the top level and the checker.
`default_nettype none

package wgm_pkg;

	localparam int SYM_W  = 8;
	localparam int KIND_W = 2;
	localparam int OUT_W  = 8;

	localparam logic [KIND_W-1:0] KIND_PATTERN = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TEXT    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END     = 2'd2;
	localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd3;

	localparam logic [SYM_W-1:0] ANY_ONE = 8'h3F;
	localparam logic [SYM_W-1:0] ANY_RUN = 8'h2A;

	// What one accepted transaction asks every cell to do.
	typedef struct packed {
		logic load;
		logic text;
		logic restart;
		logic clear;
	} wgm_cmd_t;

	// Signals handed from one cell to the next one up the chain.
	typedef struct packed {
		logic used;   // this position holds a pattern byte
		logic carry;  // empty-run closure through a star
		logic step;   // text byte advances the match into the next position
	} wgm_link_t;

endpackage

`default_nettype wire

@@ rtl/wgm_cell.sv @@
// One pattern position of the glob matcher: stored byte, fill bit and active bit.
// Depends on wgm_pkg for the command and link structs and the wildcard codes.
`default_nettype none

module wgm_cell
	import wgm_pkg::*;
#(
	parameter bit FIRST = 1'b0
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire wgm_cmd_t         cmd,
	input  wire logic [SYM_W-1:0] symbol,
	input  wire wgm_link_t        left,
	output wgm_link_t             right,
	output logic                  hit
);

	logic [SYM_W-1:0] sym_q;
	logic             used_q;
	logic             act_q;

	logic is_star;
	logic is_any;
	logic closed;
	logic take;
	logic act_next;

	assign is_star = (sym_q == ANY_RUN);
	assign is_any  = (sym_q == ANY_ONE);
	assign closed  = act_q | left.carry;
	// First free slot takes the appended byte.
	assign take    = cmd.load & left.used & ~used_q;

	assign right.used  = used_q;
	assign right.carry = closed & used_q & is_star;
	assign right.step  = closed & used_q & ~is_star & (is_any | (sym_q == symbol));

	// This cell sits at the pattern end when the left one is filled and it is not.
	assign hit      = closed & left.used & ~used_q;
	assign act_next = (closed & used_q & is_star) | left.step;

	always_ff @(posedge clk) begin
		if (take) begin
			sym_q <= symbol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			act_q  <= FIRST;
		end else begin
			if (cmd.clear) begin
				used_q <= 1'b0;
			end else if (take) begin
				used_q <= 1'b1;
			end
			if (cmd.text) begin
				act_q <= act_next;
			end else if (cmd.restart) begin
				act_q <= FIRST;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/wildcard_glob_matcher.sv @@
// An end-of-text transaction shows its result on m_tvalid in the cycle after acceptance.
// Throughput: one transaction per cycle; every cell updates its active bit in the same cycle,
// the star closure ripples through the cell chain like a carry.
// Input is held off only while a result waits on a stalled output.
// Reset (arst_n low, asynchronous): empty pattern, overflow clear, text restarted, no result.
// Top level of the glob matcher: chain of wgm_cell plus the pattern-end position and output register.
// Depends on wgm_pkg and wgm_cell.
`default_nettype none

module wildcard_glob_matcher
	import wgm_pkg::*;
#(
	parameter int MAX_PATTERN = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [SYM_W-1:0]  s_tdata,   // [7:0] symbol
	input  wire logic [KIND_W-1:0] s_tuser,   // [1:0] kind
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [OUT_W-1:0]       m_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);

	wgm_link_t              link [MAX_PATTERN+1];
	logic [MAX_PATTERN-1:0] hit_vec;
	wgm_cmd_t               cmd;
	logic                   s_fire;
	logic                   is_end;
	logic                   act_last_q;
	logic                   ovf_q;
	logic                   hit_last;
	logic                   matched;
	logic                   m_valid_q;
	logic [OUT_W-1:0]       m_data_q;

	assign s_tready = ~m_valid_q | m_tready;
	assign s_fire   = s_tvalid & s_tready;

	always_comb begin
		cmd    = '0;
		is_end = 1'b0;
		if (s_fire) begin
			unique case (s_tuser)
				KIND_PATTERN: begin
					cmd.load    = 1'b1;
					cmd.restart = 1'b1;
				end
				KIND_TEXT: begin
					cmd.text = 1'b1;
				end
				KIND_END: begin
					cmd.restart = 1'b1;
					is_end      = 1'b1;
				end
				KIND_CLEAR: begin
					cmd.clear   = 1'b1;
					cmd.restart = 1'b1;
				end
				default: begin
					cmd = '0;
				end
			endcase
		end
	end

	assign link[0] = '{used: 1'b1, carry: 1'b0, step: 1'b0};

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		wgm_cell #(
			.FIRST (i == 0)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.symbol (s_tdata),
			.left   (link[i]),
			.right  (link[i+1]),
			.hit    (hit_vec[i])
		);
	end

	// Position past the last cell: reached only with a full pattern.
	assign hit_last = link[MAX_PATTERN].used & (act_last_q | link[MAX_PATTERN].carry);
	assign matched  = (|hit_vec) | hit_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_last_q <= 1'b0;
			ovf_q      <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			if (cmd.text) begin
				act_last_q <= link[MAX_PATTERN].step;
			end else if (cmd.restart) begin
				act_last_q <= 1'b0;
			end
			// Drop bytes appended to a full pattern and flag it.
			if (cmd.clear) begin
				ovf_q <= 1'b0;
			end else if (cmd.load && link[MAX_PATTERN].used) begin
				ovf_q <= 1'b1;
			end
			if (is_end) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_end) begin
			m_data_q <= {{(OUT_W-2){1'b0}}, ovf_q, matched};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

`default_nettype wire

@@ rtl/wgm_checker.sv @@
// Port-level checks of the glob matcher, attached to the top level by bind.
// Depends on wgm_pkg and wildcard_glob_matcher_defines.svh.
`include "wildcard_glob_matcher_defines.svh"
`default_nettype none

module wgm_checker
	import wgm_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              s_tvalid,
	input wire logic              s_tready,
	input wire logic [KIND_W-1:0] s_tuser,
	input wire logic              m_tvalid,
	input wire logic              m_tready,
	input wire logic [OUT_W-1:0]  m_tdata
);

	logic s_fire;
	logic end_fire;
	logic clear_fire;

	assign s_fire     = s_tvalid & s_tready;
	assign end_fire   = s_fire & (s_tuser == KIND_END);
	assign clear_fire = s_fire & (s_tuser == KIND_CLEAR);

	`WGM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
		"stalled result changed")
	`WGM_ASSERT_NOW(a_stall_blocks_in, m_tvalid && !m_tready, !s_tready,
		"input taken while result is stalled")
	`WGM_ASSERT_NEXT(a_end_gives_result, end_fire, m_tvalid,
		"end-of-text transaction produced no result")
	`WGM_ASSERT_NEXT(a_no_spurious_result, s_fire && !end_fire && (!m_tvalid || m_tready),
		!m_tvalid, "result without end-of-text transaction")
	`WGM_ASSERT_NEXT(a_clear_drops_overflow, clear_fire ##1 end_fire, !m_tdata[1],
		"overflow reported right after pattern clear")

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (.*);

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for wildcard_glob_matcher: directed and random glob matching.
// Depends on wgm_pkg and the RTL of the matcher; a built-in predictor tracks pattern state.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
	import wgm_pkg::*;

	localparam int CAPACITY = 32;
	localparam int STALL_LIMIT = 4000;
	localparam int PRESSURE_CYCLES = 300;
	localparam logic [CAPACITY:0] START_SET = {{CAPACITY{1'b0}}, 1'b1};

	typedef logic [SYM_W-1:0] sym_t;

	typedef struct {
		logic matched;
		logic overflow;
	} verdict_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b1;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [SYM_W-1:0]  s_tdata = '0;   // [7:0] symbol
	logic [KIND_W-1:0] s_tuser = '0;   // [1:0] kind
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;        // [0] matched, [1] pattern_overflow, [7:2] zero

	// Predictor state
	sym_t              pat_bytes [CAPACITY];
	int                pat_len = 0;
	logic [CAPACITY:0] live_set = START_SET;
	logic              pat_over = 1'b0;
	verdict_t          expected_verdicts [$];

	int  error_count = 0;
	int  items_sent = 0;
	int  ends_sent = 0;
	int  verdicts_checked = 0;
	int  overflow_verdicts = 0;
	int  match_verdicts = 0;
	int  hold_request = 0;
	bit  idle_on = 1'b1;
	int  stall_cycles = 0;

	wildcard_glob_matcher #(
		.MAX_PATTERN(CAPACITY)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #10 clk = ~clk;

	// Extend the set through stars that may match an empty run.
	function automatic logic [CAPACITY:0] star_extend(input logic [CAPACITY:0] set);
		for (int i = 0; i < pat_len; i++) begin
			if (set[i] && pat_bytes[i] == ANY_RUN)
				set[i+1] = 1'b1;
		end
		return set;
	endfunction

	function automatic logic [CAPACITY:0] consume_byte(input logic [CAPACITY:0] set,
			input sym_t c);
		logic [CAPACITY:0] nxt;
		nxt = '0;
		set = star_extend(set);
		for (int i = 0; i < pat_len; i++) begin
			if (set[i]) begin
				if (pat_bytes[i] == ANY_RUN)
					nxt[i] = 1'b1;
				else if (pat_bytes[i] == ANY_ONE || pat_bytes[i] == c)
					nxt[i+1] = 1'b1;
			end
		end
		return nxt;
	endfunction

	function automatic void glob_step(input logic [KIND_W-1:0] kind, input sym_t sym);
		logic [CAPACITY:0] closed;
		verdict_t v;
		case (kind)
			KIND_PATTERN: begin
				if (pat_len < CAPACITY) begin
					pat_bytes[pat_len] = sym;
					pat_len++;
				end else begin
					pat_over = 1'b1;
				end
				live_set = START_SET;
			end
			KIND_TEXT: begin
				live_set = consume_byte(live_set, sym);
			end
			KIND_END: begin
				closed = star_extend(live_set);
				v.matched = closed[pat_len];
				v.overflow = pat_over;
				expected_verdicts.push_back(v);
				ends_sent++;
				live_set = START_SET;
			end
			default: begin
				pat_len = 0;
				pat_over = 1'b0;
				live_set = START_SET;
			end
		endcase
	endfunction

	// Offer one transaction and hold it until accepted; valid stays high afterward.
	task automatic send_item(input logic [KIND_W-1:0] kind, input sym_t sym);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= sym;
		do @(posedge clk); while (!s_tready);
		glob_step(kind, sym);
		items_sent++;
	endtask

	task automatic idle_input();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_pattern(input sym_t pat [$]);
		send_item(KIND_CLEAR, sym_t'($urandom_range(0, 255)));
		foreach (pat[i]) send_item(KIND_PATTERN, pat[i]);
	endtask

	task automatic send_text(input sym_t txt [$]);
		foreach (txt[i]) send_item(KIND_TEXT, txt[i]);
		send_item(KIND_END, sym_t'($urandom_range(0, 255)));
	endtask

	function automatic sym_t pick_symbol();
		case ($urandom_range(0, 4))
			0: return 8'h61;
			1: return 8'h62;
			2: return 8'h63;
			default: return sym_t'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic sym_t pick_pattern_byte();
		case ($urandom_range(0, 9))
			0, 1, 2: return ANY_RUN;
			3, 4:    return ANY_ONE;
			5, 6:    return 8'h61;
			7, 8:    return 8'h62;
			default: return sym_t'($urandom_range(0, 255));
		endcase
	endfunction

	// Empty pattern matches only empty text.
	task automatic test_empty_pattern();
		send_item(KIND_CLEAR, 8'h00);
		send_item(KIND_END, 8'hFF);
		send_text('{8'h00});
	endtask

	task automatic test_wildcards();
		send_pattern('{8'hFF, ANY_ONE, ANY_RUN, 8'h00});
		send_text('{8'hFF, 8'h12, 8'h00});
		send_text('{8'hFF, 8'h12, 8'h34, 8'h56, 8'h00});
		send_text('{8'hFF, 8'h00});
		// mismatch before any star, then trailing text after the final literal
		send_text('{8'h01, 8'h12, 8'h00});
		send_text('{8'hFF, 8'h12, 8'h00, 8'h7F});
		// stars alone accept empty text
		send_pattern('{ANY_RUN, ANY_RUN});
		send_item(KIND_END, 8'h00);
		send_text('{8'h80});
	endtask

	// A pattern byte appended mid-text restarts the text.
	task automatic test_append_restart();
		send_pattern('{8'h61});
		send_item(KIND_TEXT, 8'h61);
		send_item(KIND_PATTERN, 8'h62);
		send_item(KIND_END, 8'h00);
		send_text('{8'h61, 8'h62});
	endtask

	task automatic test_overflow();
		send_item(KIND_CLEAR, 8'hFF);
		send_item(KIND_PATTERN, ANY_RUN);
		repeat (CAPACITY) send_item(KIND_PATTERN, 8'h55);
		send_text('{8'h55});
		send_item(KIND_CLEAR, 8'h00);
		send_item(KIND_END, 8'h00);
	endtask

	// Stall the output for a long stretch while transactions keep coming.
	task automatic test_output_backpressure();
		hold_request = PRESSURE_CYCLES;
		idle_input();
		send_pattern('{8'h61, ANY_RUN});
		repeat (10) send_text('{8'h61, 8'h62});
	endtask

	task automatic test_random(input int count);
		int   stop_at;
		sym_t txt [$];
		int   plen;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 6))
					send_item(KIND_W'($urandom_range(0, 3)),
						sym_t'($urandom_range(0, 255)));
			end else begin
				if ($urandom_range(0, 3) != 0)
					send_item(KIND_CLEAR, sym_t'($urandom_range(0, 255)));
				plen = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 36)
					: $urandom_range(0, 6);
				repeat (plen) send_item(KIND_PATTERN, pick_pattern_byte());
				repeat ($urandom_range(1, 4)) begin
					txt = {};
					if ($urandom_range(0, 2) != 0) begin
						for (int i = 0; i < pat_len; i++) begin
							if (pat_bytes[i] == ANY_RUN)
								repeat ($urandom_range(0, 3)) txt.push_back(pick_symbol());
							else if (pat_bytes[i] == ANY_ONE)
								txt.push_back(sym_t'($urandom_range(0, 255)));
							else
								txt.push_back(pat_bytes[i]);
						end
						// break some of the derived texts
						if ($urandom_range(0, 3) == 0 && txt.size() > 0)
							txt[$urandom_range(0, txt.size() - 1)] = pick_symbol();
						else if ($urandom_range(0, 7) == 0)
							txt.push_back(pick_symbol());
					end else begin
						repeat ($urandom_range(0, 6)) txt.push_back(pick_symbol());
					end
					send_text(txt);
				end
			end
		end
	endtask

	// Output side: random stalls, plus a long hold-off on request.
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				m_tready <= 1'b0;
				n = hold_request;
				hold_request = 0;
				repeat (n) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_verdicts.size() == 0) begin
				$display("%0t: unexpected result m_tdata=%h", $time, m_tdata);
				error_count++;
			end else begin
				want = expected_verdicts.pop_front();
				verdicts_checked++;
				if (want.matched) match_verdicts++;
				if (want.overflow) overflow_verdicts++;
				if (m_tdata[0] !== want.matched) begin
					$display("%0t: matched expected %0b actual %b", $time, want.matched, m_tdata[0]);
					error_count++;
				end
				if (m_tdata[1] !== want.overflow) begin
					$display("%0t: pattern_overflow expected %0b actual %b", $time,
						want.overflow, m_tdata[1]);
					error_count++;
				end
				if (m_tdata[OUT_W-1:2] !== '0) begin
					$display("%0t: padding expected 0 actual %h", $time, m_tdata[OUT_W-1:2]);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("Verification failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_pattern();
		test_wildcards();
		test_append_restart();
		test_overflow();
		test_output_backpressure();
		test_random(320);
		idle_on = 1'b0;
		test_random(60);
		idle_input();

		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d transactions, %0d of them end of text; checked %0d results",
			items_sent, ends_sent, verdicts_checked);
		$display("Results with a match: %0d, with pattern overflow: %0d",
			match_verdicts, overflow_verdicts);
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
